// ===== sv/aou_pkg.sv =====
// ---------------------------------------------------------------------------
// aou_pkg: shared types and constants of the adam optimizer update block
// Register map, reset values and the request/response words of the
// iterative root and divide units.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aou_pkg;

  // default storage depth, parameters per pass
  localparam int unsigned MAX_PARAMS_DEFAULT = 1024;

  // register reset values
  localparam logic [31:0] BETA_FIRST_RESET  = 32'd4252017623;
  localparam logic [31:0] BETA_SECOND_RESET = 32'd4290672329;
  localparam logic [15:0] EPSILON_RESET     = 16'd1;
  localparam logic [10:0] PARAM_COUNT_RESET = 11'd1024;

  // one in unsigned q0.32, held in 33 bits
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // register index, byte address bits [3:2]
  typedef enum logic [1:0] {
    CFG_BETA_FIRST  = 2'd0,
    CFG_BETA_SECOND = 2'd1,
    CFG_EPSILON     = 2'd2,
    CFG_PARAM_COUNT = 2'd3
  } cfg_addr_t;

  // square root unit
  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  // divide unit
  typedef struct packed {
    logic        start;
    logic [63:0] numer;
    logic [40:0] denom;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [31:0] quot;
  } div_rsp_t;

endpackage

// ===== sv/aou_isqrt.sv =====
// ---------------------------------------------------------------------------
// aou_isqrt: iterative integer square root
// Floor root of a 64-bit radicand, one result bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aou_isqrt
  import aou_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  localparam logic [5:0] STEPS = 6'd32;

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [63:0] rad;
  logic [34:0] rem;
  logic [31:0] root;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;

  // one restoring step: bring down two radicand bits, try root*4+1
  assign rem_sh = {rem[32:0], rad[63:62]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = (rem_sh >= trial);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 6'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= STEPS;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // remainder and root
  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[61:0], 2'b00};
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[30:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

// ===== sv/aou_divider.sv =====
// ---------------------------------------------------------------------------
// aou_divider: iterative restoring divider
// 64-bit by 41-bit unsigned divide into 32 quotient bits, with a
// flag for quotients that do not fit in 32 bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aou_divider
  import aou_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [5:0] STEPS = 6'd32;

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [40:0] denom;
  logic [40:0] rem;
  logic [31:0] low;
  logic [31:0] quot;
  logic        sat;
  logic [41:0] rem_sh;
  logic        ge;

  // one step: bring down a numerator bit, subtract if it fits
  assign rem_sh = {rem, low[31]};
  assign ge     = (rem_sh >= {1'b0, denom});

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 6'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= STEPS;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // overflow check up front, then the bit loop
  always_ff @(posedge clk) begin
    if (req.start) begin
      sat   <= ({9'b0, req.numer} >= {req.denom, 32'b0});
      rem   <= {9'b0, req.numer[63:32]};
      low   <= req.numer[31:0];
      denom <= req.denom;
      quot  <= '0;
    end else if (busy) begin
      rem  <= ge ? 41'(rem_sh - {1'b0, denom}) : rem_sh[40:0];
      low  <= {low[30:0], 1'b0};
      quot <= {quot[30:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.sat  = sat;
  assign rsp.quot = quot;

endmodule

// ===== sv/adam_optimizer_update.sv =====
// ---------------------------------------------------------------------------
// adam_optimizer_update: fixed-point adam moment update and ascent
// Per gradient word: first and second moment update in memory, ascent
// m/(sqrt(v)+eps) and bias-corrected step size.
// ---------------------------------------------------------------------------
//  channel  | signals                                      | word
//  ---------+----------------------------------------------+----------------------
//  config   | psel penable pwrite paddr pwdata prdata pready | 4 regs at 4*i
//  gradient | grad_valid grad_ready                         | gradient learning_rate
//  result   | res_valid res_ready                           | param_index ascent
//           |                                               | step_size pass_end
//
//  a word runs the moment products on a shared 34x34 multiplier, then the
//  root, the ascent divide and the result load; once a pass has ended and
//  the first bias term is nonzero, the step-size divide follows the ascent.
//  the last word of a pass then steps the powers and roots the second bias term.
//  moments are cleared by a fill count, so no sweep follows reset.
//  only a full result register holds the sequencer in its output state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module adam_optimizer_update
  import aou_pkg::*;
#(
  parameter int unsigned MAX_PARAMS = MAX_PARAMS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               grad_valid,
  output logic               grad_ready,
  input  logic signed [31:0] gradient,
  input  logic [31:0]        learning_rate,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [9:0]         param_index,
  output logic signed [31:0] ascent,
  output logic [31:0]        step_size,
  output logic               pass_end
);

  localparam int IW  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CW  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS + 1) : 1;
  localparam int PCW = 11;
  localparam int EW  = (CW > PCW) ? CW : PCW;

  localparam logic signed [83:0] ACC_RND = 84'sh8000_0000;

  typedef enum logic [19:0] {
    ST_IDLE = 20'h00001,
    ST_READ = 20'h00002,
    ST_MA   = 20'h00004,
    ST_MB   = 20'h00008,
    ST_MC   = 20'h00010,
    ST_MD   = 20'h00020,
    ST_ME   = 20'h00040,
    ST_MF   = 20'h00080,
    ST_MG   = 20'h00100,
    ST_MH   = 20'h00200,
    ST_VW   = 20'h00400,
    ST_SQ   = 20'h00800,
    ST_DA   = 20'h01000,
    ST_DB   = 20'h02000,
    ST_OUT  = 20'h04000,
    ST_PA   = 20'h08000,
    ST_PB   = 20'h10000,
    ST_PC   = 20'h20000,
    ST_PD   = 20'h40000,
    ST_PE   = 20'h80000
  } state_t;

  state_t state;

  // configuration registers
  logic [31:0] beta_first;
  logic [31:0] beta_second;
  logic [15:0] epsilon;
  logic [10:0] param_count;

  // pass state
  logic [32:0]   pw1;
  logic [32:0]   pw2;
  logic          passes_done;
  logic [IW-1:0] counter;
  logic [CW-1:0] fill;
  logic [32:0]   root_c;

  // per-item registers
  logic signed [31:0] g_r;
  logic [31:0]        alpha;
  logic [IW-1:0]      idx;
  logic               last_r;
  logic [31:0]        m_q;
  logic [47:0]        v_q;
  logic signed [67:0] prod;
  logic signed [83:0] acc;
  logic [31:0]        m_new;
  logic [46:0]        g2;
  logic [63:0]        step_numer;
  logic [31:0]        asc_r;
  logic [31:0]        step_r;

  // moment memories
  logic [31:0] m_mem [MAX_PARAMS];
  logic [47:0] v_mem [MAX_PARAMS];

  // datapath signals
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [83:0] prod_ext;
  logic signed [83:0] prod_sh;
  logic [67:0]        prod_rnd;
  logic [67:0]        prod_g2;
  logic [32:0]        h1;
  logic [32:0]        h2;
  logic [31:0]        m_old;
  logic [47:0]        v_old;
  logic [31:0]        mag_g;
  logic [31:0]        mag_m;
  logic [47:0]        v_new;
  logic [32:0]        den;
  logic [32:0]        d1;
  logic [32:0]        n2;
  logic               need_div;
  logic [31:0]        asc_val;
  logic [31:0]        qm;
  logic [EW-1:0]      pc_ext;
  logic [EW-1:0]      eff;
  logic               last_calc;
  logic               out_load;
  logic               wr_en;

  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  assign pready     = 1'b1;
  assign grad_ready = (state == ST_IDLE);
  assign wr_en      = psel && penable && pwrite;
  assign out_load   = (state == ST_OUT) && (!res_valid || res_ready);

  // effective pass length and end-of-pass flag
  assign pc_ext = EW'(param_count);
  always_comb begin
    if (pc_ext == '0) begin
      eff = EW'(1);
    end else if (pc_ext > EW'(MAX_PARAMS)) begin
      eff = EW'(MAX_PARAMS);
    end else begin
      eff = pc_ext;
    end
  end
  assign last_calc = ((EW'(counter) + EW'(1)) >= eff);

  // operands, unwritten entries read as zero
  assign h1    = ONE_Q32 - {1'b0, beta_first};
  assign h2    = ONE_Q32 - {1'b0, beta_second};
  assign m_old = (CW'(idx) < fill) ? m_q : '0;
  assign v_old = (CW'(idx) < fill) ? v_q : '0;
  assign mag_g = g_r[31] ? (~g_r + 32'd1) : g_r;
  assign mag_m = m_new[31] ? (~m_new + 32'd1) : m_new;
  assign v_new = acc[79:32];
  assign den   = {1'b0, sq_rsp.root} + {17'b0, epsilon};

  // bias terms from the running powers
  assign d1 = ONE_Q32 - ((pw1 > ONE_Q32) ? ONE_Q32 : pw1);
  assign n2 = ONE_Q32 - ((pw2 > ONE_Q32) ? ONE_Q32 : pw2);
  assign need_div = passes_done && (d1 != '0);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MA: begin
        mul_a = {2'b00, beta_first};
        mul_b = {{2{m_old[31]}}, m_old};
      end
      ST_MB: begin
        mul_a = {1'b0, h1};
        mul_b = {{2{g_r[31]}}, g_r};
      end
      ST_MC: begin
        mul_a = {2'b00, mag_g};
        mul_b = {2'b00, mag_g};
      end
      ST_MD: begin
        mul_a = {2'b00, v_old[31:0]};
        mul_b = {2'b00, beta_second};
      end
      ST_ME: begin
        mul_a = {18'b0, v_old[47:32]};
        mul_b = {2'b00, beta_second};
      end
      ST_MF: begin
        mul_a = {2'b00, g2[31:0]};
        mul_b = {1'b0, h2};
      end
      ST_MG: begin
        mul_a = {19'b0, g2[46:32]};
        mul_b = {1'b0, h2};
      end
      ST_MH: begin
        mul_a = {2'b00, alpha};
        mul_b = {1'b0, root_c};
      end
      ST_PA: begin
        mul_a = {1'b0, pw1};
        mul_b = {2'b00, beta_first};
      end
      ST_PB: begin
        mul_a = {1'b0, pw2};
        mul_b = {2'b00, beta_second};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign prod_ext = {{16{prod[67]}}, prod};
  assign prod_sh  = {prod_ext[51:0], 32'b0};
  assign prod_rnd = prod + 68'h8000_0000;
  assign prod_g2  = prod + 68'h8000;

  // root and divide units
  always_comb begin
    sq_req.start    = (state == ST_VW) || (state == ST_PD);
    sq_req.radicand = (state == ST_VW) ? {v_new, 16'b0} : {n2[31:0], 32'b0};
  end

  always_comb begin
    div_req.start = ((state == ST_SQ) && sq_rsp.done) ||
                    ((state == ST_DA) && div_rsp.done && need_div);
    if (state == ST_SQ) begin
      div_req.numer = {8'b0, mag_m, 24'b0};
      div_req.denom = {8'b0, den};
    end else begin
      div_req.numer = step_numer;
      div_req.denom = {d1, 8'b0};
    end
  end

  aou_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .rsp (sq_rsp)
  );

  aou_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ascent from the quotient, saturated toward the sign of m
  always_comb begin
    qm      = (div_rsp.sat || (div_rsp.quot > 32'h8000_0000)) ? 32'h8000_0000 : div_rsp.quot;
    asc_val = '0;
    if (mag_m == '0) begin
      asc_val = '0;
    end else if (m_new[31]) begin
      asc_val = ~qm + 32'd1;
    end else if (div_rsp.sat || div_rsp.quot[31]) begin
      asc_val = 32'h7FFF_FFFF;
    end else begin
      asc_val = div_rsp.quot;
    end
  end

  // register read
  always_comb begin
    case (cfg_addr_t'(paddr[3:2]))
      CFG_BETA_FIRST:  prdata = beta_first;
      CFG_BETA_SECOND: prdata = beta_second;
      CFG_EPSILON:     prdata = {16'b0, epsilon};
      CFG_PARAM_COUNT: prdata = {21'b0, param_count};
      default:         prdata = '0;
    endcase
  end

  // moment memories
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      m_q <= m_mem[idx];
    end
    if (state == ST_ME) begin
      m_mem[idx] <= m_new;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      v_q <= v_mem[idx];
    end
    if (state == ST_VW) begin
      v_mem[idx] <= v_new;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      beta_first  <= BETA_FIRST_RESET;
      beta_second <= BETA_SECOND_RESET;
      epsilon     <= EPSILON_RESET;
      param_count <= PARAM_COUNT_RESET;
      pw1         <= ONE_Q32;
      pw2         <= ONE_Q32;
      passes_done <= 1'b0;
      counter     <= '0;
      fill        <= '0;
      root_c      <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        case (cfg_addr_t'(paddr[3:2]))
          CFG_BETA_FIRST:  beta_first  <= pwdata;
          CFG_BETA_SECOND: beta_second <= pwdata;
          CFG_EPSILON:     epsilon     <= pwdata[15:0];
          CFG_PARAM_COUNT: param_count <= pwdata[10:0];
          default:         ;
        endcase
      end
      // result register: loaded from the output state, emptied on a taken word
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (grad_valid) begin
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_MA;
        ST_MA:   state <= ST_MB;
        ST_MB:   state <= ST_MC;
        ST_MC:   state <= ST_MD;
        ST_MD:   state <= ST_ME;
        ST_ME:   state <= ST_MF;
        ST_MF:   state <= ST_MG;
        ST_MG:   state <= ST_MH;
        ST_MH:   state <= ST_VW;
        ST_VW: begin
          if (CW'(idx) >= fill) begin
            fill <= CW'(idx) + CW'(1);
          end
          state <= ST_SQ;
        end
        ST_SQ: begin
          if (sq_rsp.done) begin
            state <= ST_DA;
          end
        end
        ST_DA: begin
          if (div_rsp.done) begin
            state <= need_div ? ST_DB : ST_OUT;
          end
        end
        ST_DB: begin
          if (div_rsp.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            counter   <= last_r ? '0 : idx + IW'(1);
            state     <= last_r ? ST_PA : ST_IDLE;
          end
        end
        ST_PA: state <= ST_PB;
        ST_PB: begin
          pw1   <= prod_rnd[64:32];
          state <= ST_PC;
        end
        ST_PC: begin
          pw2         <= prod_rnd[64:32];
          passes_done <= 1'b1;
          state       <= ST_PD;
        end
        ST_PD: state <= ST_PE;
        ST_PE: begin
          if (sq_rsp.done) begin
            root_c <= (pw2 == '0) ? ONE_Q32 : {1'b0, sq_rsp.root};
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (grad_valid) begin
          g_r    <= gradient;
          alpha  <= learning_rate;
          idx    <= counter;
          last_r <= last_calc;
          acc    <= ACC_RND;
        end
      end
      ST_MB, ST_MC, ST_ME, ST_MG: acc <= acc + prod_ext;
      ST_MF, ST_MH:               acc <= acc + prod_sh;
      ST_MD: begin
        m_new <= acc[63:32];
        g2    <= prod_g2[62:16];
        acc   <= ACC_RND;
      end
      ST_VW: step_numer <= prod[63:0];
      ST_DA: begin
        if (div_rsp.done) begin
          asc_r <= asc_val;
          if (!need_div) begin
            step_r <= passes_done ? 32'hFFFF_FFFF : {8'b0, alpha[31:8]};
          end
        end
      end
      ST_DB: begin
        if (div_rsp.done) begin
          step_r <= div_rsp.sat ? 32'hFFFF_FFFF : div_rsp.quot;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          param_index <= 10'(idx);
          ascent      <= asc_r;
          step_size   <= step_r;
          pass_end    <= last_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/aou_checker.sv =====
// ---------------------------------------------------------------------------
// aou_checker: port-level checks of the adam optimizer update block
// Reset behavior, one word in flight, and a held result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aou_checker (
  input logic        clk,
  input logic        rst,
  input logic        grad_valid,
  input logic        grad_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [9:0]  param_index,
  input logic [31:0] ascent,
  input logic [31:0] step_size,
  input logic        pass_end
);

  // no result word right after reset
  a_rst_res: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // sequencer is back to idle after reset
  a_rst_rdy: assert property (@(posedge clk) rst |=> grad_ready)
    else $error("not ready after reset");

  // one word at a time in the iterative unit
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    grad_valid && grad_ready |=> !grad_ready)
    else $error("ready right after accepting a word");

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(param_index) &&
      $stable(ascent) && $stable(step_size) && $stable(pass_end))
    else $error("result word changed while stalled");

endmodule

bind adam_optimizer_update aou_checker u_aou_checker (
  .clk         (clk),
  .rst         (rst),
  .grad_valid  (grad_valid),
  .grad_ready  (grad_ready),
  .res_valid   (res_valid),
  .res_ready   (res_ready),
  .param_index (param_index),
  .ascent      (ascent),
  .step_size   (step_size),
  .pass_end    (pass_end)
);

// ===== bench/adam_optimizer_update_test.sv =====
// ---------------------------------------------------------------------------
// adam_optimizer_update_test: self-checking bench for the adam update block
// Drives gradient words through a valid/ready channel with random gaps,
// programs the registers over the apb port between phases, and compares
// every result word field by field with a fixed-point moment predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module adam_optimizer_update_test;
  import aou_pkg::*;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned SETTLE     = 300;
  localparam longint     CYCLE_LIMIT = 1500000;
  localparam logic [63:0] Q32_ONE    = 64'h1_0000_0000;

  typedef struct {
    logic [31:0] grad;
    logic [31:0] rate;
  } grad_word_t;

  typedef struct {
    logic [9:0]  idx;
    logic [31:0] asc;
    logic [31:0] step;
    logic        last;
  } update_word_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               grad_valid;
  logic               grad_ready;
  logic signed [31:0] gradient;
  logic [31:0]        learning_rate;
  logic               res_valid;
  logic               res_ready;
  logic [9:0]         param_index;
  logic signed [31:0] ascent;
  logic [31:0]        step_size;
  logic               pass_end;

  adam_optimizer_update dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .grad_valid(grad_valid), .grad_ready(grad_ready),
    .gradient(gradient), .learning_rate(learning_rate),
    .res_valid(res_valid), .res_ready(res_ready),
    .param_index(param_index), .ascent(ascent),
    .step_size(step_size), .pass_end(pass_end)
  );

  // predictor state and register copies
  logic [31:0] moment1 [DEPTH];
  logic [47:0] moment2 [DEPTH];
  logic [63:0] beta1_pow;
  logic [63:0] beta2_pow;
  logic        pass_seen;
  logic [9:0]  next_param;
  logic [31:0] beta1_reg;
  logic [31:0] beta2_reg;
  logic [15:0] eps_reg;
  logic [10:0] count_reg;

  grad_word_t   pending_grads[$];
  update_word_t expected_updates[$];
  int           mismatches;
  longint       cycles = 0;
  int           grad_gap;
  int           ready_hold;
  int           hold_request;
  bit           gapless;
  bit           grad_taken;

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r = 0;
    rem = x;
    b = 64'h4000_0000_0000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // one gradient word through the moment update, ascent and step size
  task automatic adam_step(input logic [31:0] g_in, input logic [31:0] rate);
    logic signed [127:0] mix;
    logic [127:0]        acc;
    logic [63:0]         mag;
    logic [63:0]         g2;
    logic [63:0]         den;
    logic [63:0]         q;
    logic [63:0]         n2;
    logic [63:0]         d1;
    logic [63:0]         rt;
    logic [127:0]        st;
    logic signed [63:0]  g;
    logic signed [63:0]  m;
    logic [10:0]         eff;
    logic [9:0]          idx;
    logic [47:0]         v;
    update_word_t        w;
    g = {{32{g_in[31]}}, g_in};
    eff = (count_reg == 0) ? 11'd1 : (count_reg > DEPTH ? 11'(DEPTH) : count_reg);
    idx = next_param;
    w.idx = idx;
    w.last = ({1'b0, idx} + 11'd1 >= eff);

    // first moment
    mix = $signed({96'b0, beta1_reg}) * $signed({{96{moment1[idx][31]}}, moment1[idx]})
        + $signed({64'b0, Q32_ONE - {32'b0, beta1_reg}}) * $signed({{64{g[63]}}, g})
        + 128'sh8000_0000;
    moment1[idx] = mix[63:32];
    m = {{32{moment1[idx][31]}}, moment1[idx]};

    // second moment
    mag = g < 0 ? -g : g;
    g2 = (mag * mag + 64'h8000) >> 16;
    acc = {80'b0, moment2[idx]} * {96'b0, beta2_reg}
        + {64'b0, g2} * {64'b0, Q32_ONE - {32'b0, beta2_reg}} + 128'h8000_0000;
    v = acc[79:32];
    moment2[idx] = v;

    // ascent
    den = isqrt({v, 16'b0}) + {48'b0, eps_reg};
    mag = m < 0 ? -m : m;
    if (den == 0) q = (mag != 0) ? Q32_ONE : 0;
    else q = (mag << 24) / den;
    if (m < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      w.asc = 32'(Q32_ONE - q);
    end else begin
      w.asc = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end

    // bias-corrected step size
    if (!pass_seen) begin
      w.step = rate >> 8;
    end else begin
      n2 = Q32_ONE - (beta2_pow > Q32_ONE ? Q32_ONE : beta2_pow);
      d1 = Q32_ONE - (beta1_pow > Q32_ONE ? Q32_ONE : beta1_pow);
      rt = (n2 >= Q32_ONE) ? Q32_ONE : isqrt(n2 << 32);
      if (d1 == 0) begin
        w.step = 32'hFFFF_FFFF;
      end else begin
        st = ({96'b0, rate} * {64'b0, rt}) / {56'b0, d1, 8'b0};
        w.step = (st > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : st[31:0];
      end
    end
    expected_updates.push_back(w);

    // pass bookkeeping
    if (w.last) begin
      next_param = 0;
      acc = {64'b0, beta1_pow} * {96'b0, beta1_reg} + 128'h8000_0000;
      beta1_pow = {31'b0, acc[64:32]};
      acc = {64'b0, beta2_pow} * {96'b0, beta2_reg} + 128'h8000_0000;
      beta2_pow = {31'b0, acc[64:32]};
      pass_seen = 1'b1;
    end else begin
      next_param = idx + 10'd1;
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gapless || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // sender side: accept at the rising edge, predict from the word
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && grad_valid && grad_ready) begin
      adam_step(gradient, learning_rate);
      grad_taken <= 1'b1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // driver: next word or a gap at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      grad_valid <= 1'b0;
    end else if (!grad_valid || grad_taken) begin
      grad_taken <= 1'b0;
      if (grad_gap > 0) begin
        grad_gap <= grad_gap - 1;
        grad_valid <= 1'b0;
      end else if (pending_grads.size() > 0) begin
        gradient <= pending_grads[0].grad;
        learning_rate <= pending_grads[0].rate;
        void'(pending_grads.pop_front());
        grad_valid <= 1'b1;
        grad_gap <= pick_gap();
      end else begin
        grad_valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (hold_request > 0) begin
      ready_hold <= hold_request;
      hold_request <= 0;
      res_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      res_ready <= 1'b0;
    end else if (gapless) begin
      res_ready <= 1'b1;
    end else begin
      res_ready <= ($urandom_range(0, 99) < 70);
      if ($urandom_range(0, 99) < 3) ready_hold <= $urandom_range(10, 60);
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (expected_updates.size() == 0) begin
        report("unexpected result word", {22'b0, param_index}, 32'b0);
      end else begin
        if (param_index !== expected_updates[0].idx)
          report("param_index", {22'b0, param_index}, {22'b0, expected_updates[0].idx});
        if (ascent !== expected_updates[0].asc)
          report("ascent", ascent, expected_updates[0].asc);
        if (step_size !== expected_updates[0].step)
          report("step_size", step_size, expected_updates[0].step);
        if (pass_end !== expected_updates[0].last)
          report("pass_end", {31'b0, pass_end}, {31'b0, expected_updates[0].last});
        void'(expected_updates.pop_front());
      end
    end
  end

  task automatic write_reg(input cfg_addr_t reg_idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      CFG_BETA_FIRST:  beta1_reg = value;
      CFG_BETA_SECOND: beta2_reg = value;
      CFG_EPSILON:     eps_reg = value[15:0];
      CFG_PARAM_COUNT: count_reg = value[10:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] b1, input logic [31:0] b2,
                           input logic [31:0] eps, input logic [31:0] cnt);
    write_reg(CFG_BETA_FIRST, b1);
    write_reg(CFG_BETA_SECOND, b2);
    write_reg(CFG_EPSILON, eps);
    write_reg(CFG_PARAM_COUNT, cnt);
  endtask

  // block is idle once every word went in and every result came back
  task automatic drain();
    while (pending_grads.size() != 0 || grad_valid || expected_updates.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send(input logic [31:0] g, input logic [31:0] rate);
    grad_word_t w;
    w.grad = g;
    w.rate = rate;
    pending_grads.push_back(w);
  endtask

  function automatic logic [31:0] rand_grad();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return 32'($signed($urandom_range(0, 400)) - 200);
      default: return 32'($signed($urandom_range(0, 1 << 29)) - (1 << 28));
    endcase
  endfunction

  function automatic logic [31:0] rand_beta();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return 32'hF000_0000 | $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return $urandom_range(1025, 2047);
      3: return 32'hFFFF_F800 | $urandom_range(1, 16);
      default: return $urandom_range(2, 9);
    endcase
  endfunction

  initial begin
    int n;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    grad_valid = 1'b0;
    gradient = '0;
    learning_rate = '0;
    res_ready = 1'b0;
    mismatches = 0;
    grad_gap = 0;
    ready_hold = 0;
    hold_request = 0;
    gapless = 1'b0;
    grad_taken = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      moment1[i] = '0;
      moment2[i] = '0;
    end
    beta1_pow = Q32_ONE;
    beta2_pow = Q32_ONE;
    pass_seen = 1'b0;
    next_param = '0;
    beta1_reg = BETA_FIRST_RESET;
    beta2_reg = BETA_SECOND_RESET;
    eps_reg = EPSILON_RESET;
    count_reg = PARAM_COUNT_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // field extremes with default decay, zero guard, short pass
    configure(BETA_FIRST_RESET, BETA_SECOND_RESET, 0, 4);
    send(32'h7FFF_FFFF, 32'h0);
    send(32'h8000_0000, 32'hFFFF_FFFF);
    send(32'h0, 32'h8000_0000);
    send(32'hFFFF_FFFF, 32'h1234_5678);
    send(32'h0100_0000, 32'hFFFF_FFFF);
    send(32'hFF00_0000, 32'h0000_00FF);
    drain();

    // zero denominator: no decay, no guard, tiny gradient gives v = 0
    configure(0, 0, 0, 1);
    send(32'd5, 32'hFFFF_FFFF);
    send(-32'sd5, 32'hFFFF_FFFF);
    send(32'd0, 32'h4000_0000);
    send(32'h8000_0000, 32'h1);
    drain();

    // pass length shrunk mid-pass, then out-of-range lengths
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF, 8);
    for (int i = 0; i < 5; i++) send(rand_grad(), $urandom);
    drain();
    write_reg(CFG_PARAM_COUNT, 3);
    send(rand_grad(), $urandom);
    send(rand_grad(), $urandom);
    drain();
    write_reg(CFG_PARAM_COUNT, 0);
    send(rand_grad(), $urandom);
    send(rand_grad(), $urandom);
    drain();
    write_reg(CFG_PARAM_COUNT, 2047);
    send(rand_grad(), $urandom);
    send(rand_grad(), $urandom);
    drain();

    // random phases, one with a long receiver stall, two with a busy sender
    for (int p = 0; p < 10; p++) begin
      configure(rand_beta(), rand_beta(), $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3),
                rand_count());
      gapless = (p == 3 || p == 7);
      if (p == 3) hold_request = 1500;
      n = $urandom_range(38, 50);
      for (int i = 0; i < n; i++) send(rand_grad(), $urandom);
      drain();
    end
    gapless = 1'b0;

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
